### src/tppq_pkg.sv
// Shared types, constants and codes of the trimming priority packet queue.
package tppq_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_W      = 25;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_BYTES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RTS        = 3'd6;

  localparam logic [16:0] RATIO_HIGH_RST = 17'd100000;
  localparam logic [16:0] RATIO_LOW_RST  = 17'd1;
  localparam logic [23:0] MAX_BYTES_RST  = 24'd65536;
  localparam logic [24:0] ECN_MIN_RST    = 25'd131072;
  localparam logic [24:0] ECN_MAX_RST    = 25'd131072;
  localparam logic [13:0] HDR_BYTES_RST  = 14'd64;

  typedef enum logic [2:0] {
    EV_LOW    = 3'd0,
    EV_HIGH   = 3'd1,
    EV_DROP   = 3'd2,
    EV_BOUNCE = 3'd3,
    EV_DEPART = 3'd4,
    EV_IDLE   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    SERV_NONE = 2'd0,
    SERV_HIGH = 2'd1,
    SERV_LOW  = 2'd2
  } serv_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DEP_RD,
    ST_DEP_MUL,
    ST_DEP_FIN,
    ST_EV_RD,
    ST_EV_OUT,
    ST_ARR,
    ST_SERV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] packet_id;
    logic [13:0] packet_bytes;
    logic        bare_header;
    logic [1:0]  packet_kind;
    logic        may_bounce;
    logic        trim_coin;
    logic [30:0] ecn_random;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [15:0] out_packet_id;
    logic [13:0] out_bytes;
    logic        trimmed;
    logic        ecn_mark;
    logic        from_high;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        may_bounce;
    logic [1:0]  packet_kind;
    logic [13:0] bytes;
    logic [15:0] id;
  } desc_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic dep_read;
    logic dep_pop;
    logic dep_fin;
    logic ev_read;
    logic evict;
    logic arrive;
    logic serve;
    logic idle_res;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic dep_ok;
    logic evict_needed;
    logic out_valid;
  } status_t;

endpackage

### src/tppq_ctrl.sv
// Controller state machine sequencing arrivals, evictions and departures.
module tppq_ctrl import tppq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.decide = 1'b1;
        if (status.kind) begin
          if (status.dep_ok) begin
            cmd.dep_read = 1'b1;
            state_nxt    = ST_DEP_RD;
          end else begin
            cmd.idle_res = 1'b1;
            state_nxt    = ST_OUT;
          end
        end else if (status.evict_needed) begin
          cmd.ev_read = 1'b1;
          state_nxt   = ST_EV_RD;
        end else begin
          state_nxt = ST_ARR;
        end
      end
      ST_DEP_RD: begin
        cmd.dep_pop = 1'b1;
        state_nxt   = ST_DEP_MUL;
      end
      ST_DEP_MUL: begin
        state_nxt = ST_DEP_FIN;
      end
      ST_DEP_FIN: begin
        cmd.dep_fin = 1'b1;
        state_nxt   = ST_SERV;
      end
      ST_EV_RD: begin
        cmd.evict = 1'b1;
        state_nxt = ST_EV_OUT;
      end
      ST_EV_OUT: begin
        if (!status.out_valid) begin
          state_nxt = ST_ARR;
        end
      end
      ST_ARR: begin
        cmd.arrive = 1'b1;
        state_nxt  = ST_SERV;
      end
      ST_SERV: begin
        cmd.serve = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/tppq_dp.sv
// Datapath: configuration, descriptor FIFOs, byte totals, WRR, ECN ramp, result register.
module tppq_dp import tppq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output status_t              status
);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(FIFO_DEPTH - 1) : p - AW'(1);
  endfunction

  logic [16:0] ratio_high_r, ratio_low_r;
  logic [23:0] max_bytes_r;
  logic [24:0] ecn_min_r, ecn_max_r;
  logic [13:0] hdr_bytes_r;
  logic        rts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_high_r <= RATIO_HIGH_RST;
      ratio_low_r  <= RATIO_LOW_RST;
      max_bytes_r  <= MAX_BYTES_RST;
      ecn_min_r    <= ECN_MIN_RST;
      ecn_max_r    <= ECN_MAX_RST;
      hdr_bytes_r  <= HDR_BYTES_RST;
      rts_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO_HIGH: ratio_high_r <= cfg_data[16:0];
        CFG_RATIO_LOW:  ratio_low_r  <= cfg_data[16:0];
        CFG_MAX_BYTES:  max_bytes_r  <= cfg_data[23:0];
        CFG_ECN_MIN:    ecn_min_r    <= cfg_data;
        CFG_ECN_MAX:    ecn_max_r    <= cfg_data;
        CFG_HDR_BYTES:  hdr_bytes_r  <= cfg_data[13:0];
        CFG_RTS:        rts_r        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  in_item_t   in_r;
  logic       to_low_r, to_low_nxt;
  logic [AW-1:0]    low_head_r, low_head_nxt, low_tail_r, low_tail_nxt;
  logic [AW-1:0]    high_head_r, high_head_nxt, high_tail_r, high_tail_nxt;
  logic [CNT_W-1:0] low_cnt_r, low_cnt_nxt, high_cnt_r, high_cnt_nxt;
  logic [24:0] low_tot_r, low_tot_nxt;
  logic [25:0] high_tot_r, high_tot_nxt;
  logic [17:0] wrr_r, wrr_nxt;
  serv_t       serv_r, serv_nxt;
  desc_t       low_rd_r, high_rd_r;
  desc_t       dep_r, dep_nxt;
  logic        dep_hi_r, dep_hi_nxt;
  logic [56:0] lhs_r;
  logic [55:0] rhs_r;
  logic        gt_max_r, gt_min_r;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  desc_t low_mem [FIFO_DEPTH];
  desc_t high_mem [FIFO_DEPTH];

  logic            low_we, high_we;
  logic [AW-1:0]   low_waddr, high_waddr;
  desc_t           low_wdata, high_wdata;
  logic [AW-1:0]   low_raddr;

  always_ff @(posedge clk) begin
    if (low_we) begin
      low_mem[low_waddr] <= low_wdata;
    end
    if (cmd.dep_read || cmd.ev_read) begin
      low_rd_r <= low_mem[low_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (high_we) begin
      high_mem[high_waddr] <= high_wdata;
    end
    if (cmd.dep_read) begin
      high_rd_r <= high_mem[high_head_r];
    end
  end

  assign low_raddr = cmd.ev_read ? ptr_dec(low_tail_r) : low_head_r;

  logic [25:0] low_sum;
  logic        over, to_low_c;
  assign low_sum  = {1'b0, low_tot_r} + 26'(in_r.packet_bytes);
  assign over     = low_sum > {2'b00, max_bytes_r};
  assign to_low_c = !in_r.bare_header && (!over || in_r.trim_coin);

  assign status.kind         = in_r.kind;
  assign status.dep_ok       = (serv_r == SERV_HIGH) ? (high_cnt_r != '0) :
                               (serv_r == SERV_LOW)  ? (low_cnt_r != '0) : 1'b0;
  assign status.evict_needed = to_low_c && over && (low_cnt_r != '0);
  assign status.out_valid    = out_valid_r;

  // offer toward the high queue, shared by eviction and arrival
  desc_t       offer_d;
  logic [13:0] arr_bytes;
  logic        offer_over, offer_full;
  event_t      offer_ev;
  assign arr_bytes = in_r.bare_header ? in_r.packet_bytes : hdr_bytes_r;
  always_comb begin
    if (cmd.evict) begin
      offer_d             = low_rd_r;
      offer_d.bytes       = hdr_bytes_r;
    end else begin
      offer_d.id          = in_r.packet_id;
      offer_d.bytes       = arr_bytes;
      offer_d.packet_kind = in_r.packet_kind;
      offer_d.may_bounce  = in_r.may_bounce;
    end
  end
  assign offer_over = ({1'b0, high_tot_r} + 27'(offer_d.bytes)) > {2'b00, max_bytes_r, 1'b0};
  assign offer_full = high_cnt_r >= CNT_W'(FIFO_DEPTH);
  always_comb begin
    if (offer_over) begin
      offer_ev = (rts_r && offer_d.may_bounce) ? EV_BOUNCE : EV_DROP;
    end else if (offer_full) begin
      offer_ev = EV_DROP;
    end else begin
      offer_ev = EV_HIGH;
    end
  end

  // ECN ramp: rnd < floor(N/D) is (rnd + 1) * D <= N
  logic [24:0] q_diff, ramp_span;
  assign q_diff    = low_tot_r - ecn_min_r;
  assign ramp_span = ecn_max_r - ecn_min_r;

  always_ff @(posedge clk) begin
    lhs_r    <= 57'(32'(in_r.ecn_random) + 32'd1) * 57'(ramp_span);
    rhs_r    <= {q_diff, 31'b0} - 56'(q_diff);
    gt_max_r <= low_tot_r > ecn_max_r;
    gt_min_r <= low_tot_r > ecn_min_r;
  end

  desc_t       dep_src;
  logic        mark;
  logic [18:0] wrr_inc;
  logic [17:0] wrr_new;
  assign dep_src = (serv_r == SERV_HIGH) ? high_rd_r : low_rd_r;
  assign mark    = gt_max_r || (gt_min_r && ({1'b0, rhs_r} >= lhs_r));
  assign wrr_inc = {1'b0, wrr_r} + 19'd1;
  assign wrr_new = (wrr_inc >= ({2'b00, ratio_high_r} + {2'b00, ratio_low_r})) ? '0 :
                   wrr_inc[17:0];

  always_comb begin
    to_low_nxt    = to_low_r;
    low_head_nxt  = low_head_r;
    low_tail_nxt  = low_tail_r;
    low_cnt_nxt   = low_cnt_r;
    high_head_nxt = high_head_r;
    high_tail_nxt = high_tail_r;
    high_cnt_nxt  = high_cnt_r;
    low_tot_nxt   = low_tot_r;
    high_tot_nxt  = high_tot_r;
    wrr_nxt       = wrr_r;
    serv_nxt      = serv_r;
    dep_nxt       = dep_r;
    dep_hi_nxt    = dep_hi_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    low_we        = 1'b0;
    low_waddr     = low_tail_r;
    low_wdata     = '0;
    high_we       = 1'b0;
    high_waddr    = high_tail_r;
    high_wdata    = offer_d;

    if (cmd.decide) begin
      to_low_nxt = to_low_c;
    end

    if (cmd.idle_res) begin
      serv_nxt      = SERV_NONE;
      out_nxt       = '0;
      out_nxt.event_res = EV_IDLE;
      out_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
    end

    if (cmd.dep_pop) begin
      dep_nxt    = dep_src;
      dep_hi_nxt = (serv_r == SERV_HIGH);
      if (serv_r == SERV_HIGH) begin
        high_head_nxt = ptr_inc(high_head_r);
        high_cnt_nxt  = high_cnt_r - CNT_W'(1);
        high_tot_nxt  = high_tot_r - 26'(dep_src.bytes);
      end else begin
        low_head_nxt = ptr_inc(low_head_r);
        low_cnt_nxt  = low_cnt_r - CNT_W'(1);
        low_tot_nxt  = low_tot_r - 25'(dep_src.bytes);
      end
    end

    if (cmd.dep_fin) begin
      out_nxt.event_res     = EV_DEPART;
      out_nxt.out_packet_id = dep_r.id;
      out_nxt.out_bytes     = dep_r.bytes;
      out_nxt.trimmed       = 1'b0;
      out_nxt.ecn_mark      = mark && (!dep_hi_r || (dep_r.packet_kind == 2'd0));
      out_nxt.from_high     = dep_hi_r;
      out_nxt.last          = 1'b1;
      out_valid_nxt         = 1'b1;
      serv_nxt              = SERV_NONE;
    end

    if (cmd.evict) begin
      low_tail_nxt = ptr_dec(low_tail_r);
      low_cnt_nxt  = low_cnt_r - CNT_W'(1);
      low_tot_nxt  = low_tot_r - 25'(low_rd_r.bytes);
      if (offer_ev == EV_HIGH) begin
        high_we       = 1'b1;
        high_tail_nxt = ptr_inc(high_tail_r);
        high_cnt_nxt  = high_cnt_r + CNT_W'(1);
        high_tot_nxt  = high_tot_r + 26'(hdr_bytes_r);
      end
      out_nxt.event_res     = offer_ev;
      out_nxt.out_packet_id = low_rd_r.id;
      out_nxt.out_bytes     = hdr_bytes_r;
      out_nxt.trimmed       = 1'b1;
      out_nxt.ecn_mark      = 1'b0;
      out_nxt.from_high     = 1'b0;
      out_nxt.last          = 1'b0;
      out_valid_nxt         = 1'b1;
    end

    if (cmd.arrive) begin
      out_nxt.out_packet_id = in_r.packet_id;
      out_nxt.ecn_mark      = 1'b0;
      out_nxt.from_high     = 1'b0;
      out_nxt.last          = 1'b1;
      out_valid_nxt         = 1'b1;
      if (to_low_r) begin
        out_nxt.out_bytes = in_r.packet_bytes;
        out_nxt.trimmed   = 1'b0;
        if (low_cnt_r >= CNT_W'(FIFO_DEPTH)) begin
          out_nxt.event_res = EV_DROP;
        end else begin
          out_nxt.event_res = EV_LOW;
          low_we            = 1'b1;
          low_wdata.id          = in_r.packet_id;
          low_wdata.bytes       = in_r.packet_bytes;
          low_wdata.packet_kind = in_r.packet_kind;
          low_wdata.may_bounce  = in_r.may_bounce;
          low_tail_nxt      = ptr_inc(low_tail_r);
          low_cnt_nxt       = low_cnt_r + CNT_W'(1);
          low_tot_nxt       = low_tot_r + 25'(in_r.packet_bytes);
        end
      end else begin
        out_nxt.out_bytes = arr_bytes;
        out_nxt.trimmed   = !in_r.bare_header;
        out_nxt.event_res = offer_ev;
        if (offer_ev == EV_HIGH) begin
          high_we       = 1'b1;
          high_tail_nxt = ptr_inc(high_tail_r);
          high_cnt_nxt  = high_cnt_r + CNT_W'(1);
          high_tot_nxt  = high_tot_r + 26'(arr_bytes);
        end
      end
    end

    if (cmd.serve && (serv_r == SERV_NONE)) begin
      if ((high_cnt_r != '0) && (low_cnt_r != '0)) begin
        wrr_nxt  = wrr_new;
        serv_nxt = (wrr_new < {1'b0, ratio_high_r}) ? SERV_HIGH : SERV_LOW;
      end else if (high_cnt_r != '0) begin
        serv_nxt = SERV_HIGH;
      end else if (low_cnt_r != '0) begin
        serv_nxt = SERV_LOW;
      end else begin
        serv_nxt = SERV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    to_low_r <= to_low_nxt;
    dep_r    <= dep_nxt;
    dep_hi_r <= dep_hi_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_head_r  <= '0;
      low_tail_r  <= '0;
      low_cnt_r   <= '0;
      high_head_r <= '0;
      high_tail_r <= '0;
      high_cnt_r  <= '0;
      low_tot_r   <= '0;
      high_tot_r  <= '0;
      wrr_r       <= '0;
      serv_r      <= SERV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      low_head_r  <= low_head_nxt;
      low_tail_r  <= low_tail_nxt;
      low_cnt_r   <= low_cnt_nxt;
      high_head_r <= high_head_nxt;
      high_tail_r <= high_tail_nxt;
      high_cnt_r  <= high_cnt_nxt;
      low_tot_r   <= low_tot_nxt;
      high_tot_r  <= high_tot_nxt;
      wrr_r       <= wrr_nxt;
      serv_r      <= serv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/trimming_priority_packet_queue_unit.sv
// Top level of the trimming priority packet queue: controller and datapath.
//
//   port group  direction  handshake           payload
//   in_         request    in_valid/in_stall   in_item_t
//   out_        result     out_valid/out_stall out_item_t
//   cfg_        config     cfg_we              cfg_index, cfg_data
//
// One request at a time. A finish passes through memory read, byte update, ECN
// multiply, compare and service pick, then waits on the output; an idle finish goes straight to the output.
// An arrival passes through arrive and service pick; when it evicts, it first waits on the eviction result.
// Reset is synchronous; both FIFOs start empty and need no clearing pass.
// Out_stall holds the result register and the next request waits behind it.
module trimming_priority_packet_queue_unit import tppq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  tppq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tppq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### tb/tb_trimming_priority_packet_queue_unit.sv
// Testbench for the trimming priority packet queue: predictor, driver, monitor and phases.
module tb_trimming_priority_packet_queue_unit;
  import tppq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  trimming_priority_packet_queue_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // queue model state and register copies
  longint unsigned r_ratio_high, r_ratio_low, r_max_bytes, r_ecn_min, r_ecn_max;
  longint unsigned r_hdr_bytes, r_rts;
  desc_t           low_q[$];
  desc_t           high_q[$];
  longint unsigned low_bytes, high_bytes, wrr_pos;
  serv_t           serving;

  in_item_t  request_q[$];
  out_item_t expected_q[$];
  int        errors;
  int        n_requests, n_results, n_idle_res;
  int        idle_cycles;
  bit        in_taken;
  bit        calm;
  int        in_gap, stall_left;

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_results, field, got, want);
    errors++;
  endtask

  function automatic bit ecn_decide(input longint unsigned rnd);
    longint unsigned p;
    if (low_bytes > r_ecn_max) return 1'b1;
    if (low_bytes > r_ecn_min) begin
      p = (64'h7FFF_FFFF * (low_bytes - r_ecn_min)) / (r_ecn_max - r_ecn_min);
      return rnd < p;
    end
    return 1'b0;
  endfunction

  function automatic void pick_queue();
    if (high_q.size() != 0 && low_q.size() != 0) begin
      wrr_pos++;
      if (wrr_pos >= r_ratio_high + r_ratio_low) wrr_pos = 0;
      serving = (wrr_pos < r_ratio_high) ? SERV_HIGH : SERV_LOW;
    end else if (high_q.size() != 0) begin
      serving = SERV_HIGH;
    end else if (low_q.size() != 0) begin
      serving = SERV_LOW;
    end else begin
      serving = SERV_NONE;
    end
  endfunction

  function automatic event_t offer_header(input desc_t d);
    if (high_bytes + d.bytes > 2 * r_max_bytes) begin
      if (r_rts != 0 && d.may_bounce) return EV_BOUNCE;
      return EV_DROP;
    end
    if (high_q.size() >= FIFO_DEPTH) return EV_DROP;
    high_q.push_back(d);
    high_bytes += d.bytes;
    return EV_HIGH;
  endfunction

  function automatic void predict_results(input in_item_t it);
    out_item_t r;
    desc_t     d;
    desc_t     b;
    int        depth;
    r = '0;
    if (it.kind) begin
      depth = (serving == SERV_HIGH) ? high_q.size() : low_q.size();
      if (serving == SERV_NONE || depth == 0) begin
        serving = SERV_NONE;
        r.event_res = EV_IDLE;
        r.last = 1'b1;
        expected_q.push_back(r);
        return;
      end
      if (serving == SERV_LOW) begin
        d = low_q[0];
        low_q.delete(0);
        low_bytes -= d.bytes;
        r.ecn_mark = ecn_decide(it.ecn_random);
      end else begin
        d = high_q[0];
        high_q.delete(0);
        high_bytes -= d.bytes;
        if (d.packet_kind == 2'd0) r.ecn_mark = ecn_decide(it.ecn_random);
        r.from_high = 1'b1;
      end
      r.event_res = EV_DEPART;
      r.out_packet_id = d.id;
      r.out_bytes = d.bytes;
      r.last = 1'b1;
      expected_q.push_back(r);
      serving = SERV_NONE;
      pick_queue();
      return;
    end
    d.id = it.packet_id;
    d.bytes = it.packet_bytes;
    d.packet_kind = it.packet_kind;
    d.may_bounce = it.may_bounce;
    if (!it.bare_header && (low_bytes + d.bytes <= r_max_bytes || it.trim_coin)) begin
      if (low_bytes + d.bytes > r_max_bytes && low_q.size() != 0) begin
        b = low_q.pop_back();
        low_bytes -= b.bytes;
        b.bytes = r_hdr_bytes[13:0];
        r = '0;
        r.event_res = offer_header(b);
        r.out_packet_id = b.id;
        r.out_bytes = b.bytes;
        r.trimmed = 1'b1;
        expected_q.push_back(r);
      end
      r = '0;
      if (low_q.size() >= FIFO_DEPTH) begin
        r.event_res = EV_DROP;
      end else begin
        low_q.push_back(d);
        low_bytes += d.bytes;
        r.event_res = EV_LOW;
      end
    end else begin
      r = '0;
      if (!it.bare_header) begin
        d.bytes = r_hdr_bytes[13:0];
        r.trimmed = 1'b1;
      end
      r.event_res = offer_header(d);
    end
    r.out_packet_id = d.id;
    r.out_bytes = d.bytes;
    r.last = 1'b1;
    expected_q.push_back(r);
    if (serving == SERV_NONE) pick_queue();
  endfunction

  // accept requests into the model, check results against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result event %0d id %0d", out_data.event_res,
                   out_data.out_packet_id);
          errors++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (out_data.event_res !== e.event_res)
            report_mismatch("event_res", out_data.event_res, e.event_res);
          if (out_data.out_packet_id !== e.out_packet_id)
            report_mismatch("out_packet_id", out_data.out_packet_id, e.out_packet_id);
          if (out_data.out_bytes !== e.out_bytes)
            report_mismatch("out_bytes", out_data.out_bytes, e.out_bytes);
          if (out_data.trimmed !== e.trimmed)
            report_mismatch("trimmed", out_data.trimmed, e.trimmed);
          if (out_data.ecn_mark !== e.ecn_mark)
            report_mismatch("ecn_mark", out_data.ecn_mark, e.ecn_mark);
          if (out_data.from_high !== e.from_high)
            report_mismatch("from_high", out_data.from_high, e.from_high);
          if (out_data.last !== e.last)
            report_mismatch("last", out_data.last, e.last);
          if (e.event_res == EV_IDLE) n_idle_res++;
        end
        n_results++;
      end
      if (in_valid && !in_stall) begin
        predict_results(in_data);
        n_requests++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog expired with %0d results outstanding", expected_q.size());
          $display("tb_trimming_priority_packet_queue_unit failed");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled request
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (request_q.size() != 0) begin
      in_data <= request_q[0];
      request_q.delete(0);
      in_valid <= 1'b1;
      in_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      CFG_RATIO_HIGH: r_ratio_high = val & 64'h1FFFF;
      CFG_RATIO_LOW:  r_ratio_low = val & 64'h1FFFF;
      CFG_MAX_BYTES:  r_max_bytes = val & 64'hFFFFFF;
      CFG_ECN_MIN:    r_ecn_min = val & 64'h1FFFFFF;
      CFG_ECN_MAX:    r_ecn_max = val & 64'h1FFFFFF;
      CFG_HDR_BYTES:  r_hdr_bytes = val & 64'h3FFF;
      CFG_RTS:        r_rts = val & 64'h1;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input longint unsigned rh, input longint unsigned rl,
                           input longint unsigned mx, input longint unsigned emin,
                           input longint unsigned emax, input longint unsigned hb,
                           input longint unsigned rts);
    cfg_write(CFG_RATIO_HIGH, rh);
    cfg_write(CFG_RATIO_LOW, rl);
    cfg_write(CFG_MAX_BYTES, mx);
    cfg_write(CFG_ECN_MIN, emin);
    cfg_write(CFG_ECN_MAX, emax);
    cfg_write(CFG_HDR_BYTES, hb);
    cfg_write(CFG_RTS, rts);
  endtask

  task automatic drain();
    wait (request_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_request(input int fin_pct, input int hdr_pct,
                                            input int max_pkt);
    in_item_t it;
    it = '0;
    it.packet_id = 16'($urandom_range(0, 65535));
    it.packet_kind = 2'($urandom_range(0, 3));
    it.may_bounce = 1'($urandom_range(0, 1));
    it.trim_coin = 1'($urandom_range(0, 1));
    it.ecn_random = 31'($urandom);
    it.kind = ($urandom_range(0, 99) < fin_pct);
    it.bare_header = ($urandom_range(0, 99) < hdr_pct);
    case ($urandom_range(0, 19))
      0: it.packet_bytes = 14'd1;
      1: it.packet_bytes = 14'd16383;
      2: it.packet_bytes = 14'($urandom_range(1, 16383));
      default: it.packet_bytes = 14'($urandom_range(1, max_pkt));
    endcase
    return it;
  endfunction

  function automatic in_item_t directed(input bit k, input int bytes, input bit hdr,
                                        input int pk, input bit mb, input bit coin);
    in_item_t it;
    it = '0;
    it.kind = k;
    it.packet_id = 16'($urandom_range(0, 65535));
    it.packet_bytes = 14'(bytes);
    it.bare_header = hdr;
    it.packet_kind = 2'(pk);
    it.may_bounce = mb;
    it.trim_coin = coin;
    it.ecn_random = 31'($urandom);
    return it;
  endfunction

  task automatic add_random(input int count, input int fin_pct, input int hdr_pct,
                            input int max_pkt);
    for (int i = 0; i < count; i++) request_q.push_back(make_request(fin_pct, hdr_pct, max_pkt));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    n_requests = 0;
    n_results = 0;
    n_idle_res = 0;
    idle_cycles = 0;
    calm = 1'b0;
    in_gap = 0;
    stall_left = 0;
    r_ratio_high = RATIO_HIGH_RST;
    r_ratio_low = RATIO_LOW_RST;
    r_max_bytes = MAX_BYTES_RST;
    r_ecn_min = ECN_MIN_RST;
    r_ecn_max = ECN_MAX_RST;
    r_hdr_bytes = HDR_BYTES_RST;
    r_rts = 0;
    low_bytes = 0;
    high_bytes = 0;
    wrr_pos = 0;
    serving = SERV_NONE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, directed corners
    request_q.push_back(directed(1, 1, 0, 0, 0, 0));
    request_q.push_back(directed(0, 1, 0, 0, 0, 0));
    request_q.push_back(directed(0, 16383, 0, 1, 1, 0));
    request_q.push_back(directed(0, 16383, 0, 2, 0, 1));
    request_q.push_back(directed(0, 16383, 0, 3, 1, 1));
    request_q.push_back(directed(0, 16383, 0, 0, 1, 1));
    request_q.push_back(directed(0, 16383, 0, 0, 1, 0));
    request_q.push_back(directed(0, 100, 1, 0, 1, 0));
    request_q.push_back(directed(0, 16383, 1, 3, 0, 1));
    for (int i = 0; i < 8; i++) request_q.push_back(directed(1, 1, 0, 0, 0, 0));
    request_q.push_back(directed(1, 1, 0, 0, 0, 0));
    request_q.push_back(directed(0, 5000, 0, 0, 0, 1));
    request_q.push_back(directed(1, 1, 0, 0, 0, 0));
    drain();

    // small low queue, bouncing on, gentle ramp; sender pauses half way
    configure(3, 2, 2000, 500, 1500, 64, 1);
    add_random(100, 35, 20, 600);
    wait (request_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    add_random(100, 35, 20, 600);
    drain();

    // extremes: one byte limit, largest header, full ramp span, no back-pressure
    calm = 1'b1;
    configure(131071, 0, 1, 0, 33554431, 16383, 0);
    add_random(150, 40, 20, 16383);
    drain();
    calm = 1'b0;

    // zero ratios, huge limit: fill both descriptor stores past capacity
    configure(0, 0, 16777215, 0, 0, 1, 1);
    add_random(280, 0, 0, 64);
    add_random(280, 0, 100, 64);
    add_random(90, 70, 10, 64);
    drain();

    // low queue favoured, tiny limit, shallow ramp
    configure(1, 131071, 300, 100, 100000, 14, 1);
    add_random(150, 35, 15, 200);
    drain();

    $display("covered %0d requests and %0d results (%0d idle finishes) over five settings",
             n_requests, n_results, n_idle_res);
    if (errors == 0) begin
      $display("tb_trimming_priority_packet_queue_unit passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_trimming_priority_packet_queue_unit failed");
    end
    $finish;
  end
endmodule

### trimming_priority_packet_queue_unit.f
src/tppq_pkg.sv
src/tppq_ctrl.sv
src/tppq_dp.sv
src/trimming_priority_packet_queue_unit.sv
tb/tb_trimming_priority_packet_queue_unit.sv
